/* hdl/tiq_pkg.sv */
// shared types and constants for the timestamped input queue
package tiq_pkg;

	localparam int TIME_W  = 48;
	localparam int CHAN_W  = 16;
	localparam int CHANS_W = 4 * CHAN_W;
	localparam int STEP_W  = 32;
	localparam int PER_W   = 16;
	localparam int LIM_W   = STEP_W + 1 + PER_W;

	localparam logic [PER_W-1:0] PERIOD_RESET = 16'd1000;

	typedef enum logic [1:0] {
		CMD_PUSH  = 2'd0,
		CMD_TICK  = 2'd1,
		CMD_CLEAR = 2'd2,
		CMD_NOP   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STATUS_OK   = 2'd0,
		STATUS_OLD  = 2'd1,
		STATUS_FULL = 2'd2,
		STATUS_RSVD = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LIMIT,
		ST_CHECK
	} state_t;

	typedef struct packed {
		logic accept;
		logic load_limit;
		logic take;
		logic finish;
	} ctrl_cmd_t;

	typedef struct packed {
		logic drain_hit;
	} dp_status_t;

endpackage

/* hdl/tiq_ctrl.sv */
// controller: request handshake and the step tick drain sequence
module tiq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  tiq_pkg::cmd_t     cmd,
	output logic              m_tvalid,
	input  logic              m_tready,
	input  tiq_pkg::dp_status_t dp_sts,
	output tiq_pkg::ctrl_cmd_t  ctl
);
	import tiq_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		ctl      = '0;
		out_load = 1'b0;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready   = !out_valid_q || m_tready;
				ctl.accept = s_tvalid && s_tready;
				if (ctl.accept) begin
					if (cmd == CMD_TICK) begin
						state_d = ST_LIMIT;
					end else begin
						out_load = 1'b1;
					end
				end
			end
			ST_LIMIT: begin
				ctl.load_limit = 1'b1;
				state_d        = ST_CHECK;
			end
			ST_CHECK: begin
				if (dp_sts.drain_hit) begin
					ctl.take = 1'b1;
				end else begin
					ctl.finish = 1'b1;
					out_load   = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign m_tvalid = out_valid_q;

endmodule

/* hdl/tiq_datapath.sv */
// datapath: sample ring, pointers, push checks, step limit and latched channels
module tiq_datapath #(
	parameter int QUEUE_DEPTH = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [tiq_pkg::PER_W-1:0]     cfg_wdata,
	input  tiq_pkg::cmd_t                 cmd,
	input  logic [tiq_pkg::TIME_W-1:0]    time_us,
	input  logic [tiq_pkg::CHANS_W-1:0]   chans_in,
	input  tiq_pkg::ctrl_cmd_t            ctl,
	output tiq_pkg::dp_status_t           dp_sts,
	output tiq_pkg::status_t              status,
	output logic                          fresh_frame,
	output logic [tiq_pkg::CHANS_W-1:0]   chans_out,
	output logic [tiq_pkg::STEP_W-1:0]    step_number
);
	import tiq_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam int SLOT_W = TIME_W + CHANS_W;

	logic [SLOT_W-1:0] mem [QUEUE_DEPTH];
	logic [SLOT_W-1:0] rd_data_q;

	logic [PER_W-1:0]   period_q;
	logic [PTR_W-1:0]   rd_ptr_q, wr_ptr_q;
	logic [TIME_W-1:0]  last_time_q;
	logic               any_q;
	logic [CHANS_W-1:0] chans_q;
	logic [STEP_W-1:0]  step_q;
	logic [LIM_W-1:0]   limit_q;
	status_t            status_q;
	logic               fresh_q;

	logic [PTR_W-1:0]   wr_next, rd_next, rd_addr;
	logic               too_old, full, push_ok;
	logic [STEP_W:0]    step_inc;
	logic [LIM_W-1:0]   limit_prod;

	assign wr_next = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
	assign rd_next = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
	assign too_old = any_q && (time_us < last_time_q);
	assign full    = (wr_next == rd_ptr_q);
	assign push_ok = ctl.accept && (cmd == CMD_PUSH) && !too_old && !full;
	assign rd_addr = ctl.take ? rd_next : rd_ptr_q;

	// limit is taken from the step count before the increment, at full width
	assign step_inc   = {1'b0, step_q} + (STEP_W + 1)'(1);
	assign limit_prod = {{PER_W{1'b0}}, step_inc} * {{(STEP_W + 1){1'b0}}, period_q};

	assign dp_sts.drain_hit = (rd_ptr_q != wr_ptr_q)
		&& ({{(LIM_W - TIME_W){1'b0}}, rd_data_q[TIME_W-1:0]} < limit_q);

	always_ff @(posedge clk) begin
		if (push_ok) begin
			mem[wr_ptr_q] <= {chans_in, time_us};
		end
		rd_data_q <= mem[rd_addr];
		if (ctl.load_limit) begin
			limit_q <= limit_prod;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q    <= PERIOD_RESET;
			rd_ptr_q    <= '0;
			wr_ptr_q    <= '0;
			last_time_q <= '0;
			any_q       <= 1'b0;
			chans_q     <= '0;
			step_q      <= '0;
			status_q    <= STATUS_OK;
			fresh_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				period_q <= cfg_wdata;
			end
			if (ctl.accept) begin
				fresh_q  <= 1'b0;
				status_q <= STATUS_OK;
				case (cmd)
					CMD_PUSH: begin
						if (too_old) begin
							status_q <= STATUS_OLD;
						end else if (full) begin
							status_q <= STATUS_FULL;
						end else begin
							wr_ptr_q    <= wr_next;
							last_time_q <= time_us;
							any_q       <= 1'b1;
						end
					end
					CMD_CLEAR: begin
						rd_ptr_q    <= '0;
						wr_ptr_q    <= '0;
						last_time_q <= '0;
						any_q       <= 1'b0;
						chans_q     <= '0;
						step_q      <= '0;
					end
					default: begin
					end
				endcase
			end
			if (ctl.take) begin
				chans_q  <= rd_data_q[SLOT_W-1:TIME_W];
				rd_ptr_q <= rd_next;
				fresh_q  <= 1'b1;
			end
			if (ctl.finish) begin
				step_q <= step_q + STEP_W'(1);
			end
		end
	end

	assign status      = status_q;
	assign fresh_frame = fresh_q;
	assign chans_out   = chans_q;
	assign step_number = step_q;

endmodule

/* hdl/timestamped_input_queue_top.sv */
// top level of the timestamped input queue
//
// channel | signals                          | contents
// --------+----------------------------------+-----------------------------------------
// in      | s_tvalid s_tready s_tdata s_tuser | one request: command, timestamp, channels
// out     | m_tvalid m_tready m_tdata m_tuser | one result per request
// cfg     | cfg_we cfg_wdata                  | step period in microseconds
//
// push, clear and unused commands give a result the cycle after they are taken; a step
// tick loads the step limit in ST_LIMIT, then drains in ST_CHECK, one ring read per cycle
// the result is held in an output register until taken; new requests wait on it
// reset clears pointers, latched channels and step count; ring contents are not cleared
module timestamped_input_queue_top #(
	parameter int QUEUE_DEPTH = 256
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [111:0] s_tdata,  // time_us[47:0], roll_in, pitch_in, yaw_in, throttle_in
	input  logic [1:0]   s_tuser,  // cmd[1:0]
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [95:0]  m_tdata,  // roll_out, pitch_out, yaw_out, throttle_out, step_number
	output logic [2:0]   m_tuser,  // status[1:0], fresh_frame
	input  logic         cfg_we,
	input  logic [15:0]  cfg_wdata
);
	import tiq_pkg::*;

	cmd_t       cmd;
	ctrl_cmd_t  ctl;
	dp_status_t dp_sts;
	status_t    status;
	logic       fresh_frame;
	logic [CHANS_W-1:0] chans_out;
	logic [STEP_W-1:0]  step_number;

	assign cmd = cmd_t'(s_tuser);

	tiq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.cmd      (cmd),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.dp_sts   (dp_sts),
		.ctl      (ctl)
	);

	tiq_datapath #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.cmd         (cmd),
		.time_us     (s_tdata[TIME_W-1:0]),
		.chans_in    (s_tdata[TIME_W+CHANS_W-1:TIME_W]),
		.ctl         (ctl),
		.dp_sts      (dp_sts),
		.status      (status),
		.fresh_frame (fresh_frame),
		.chans_out   (chans_out),
		.step_number (step_number)
	);

	assign m_tdata = {step_number, chans_out};
	assign m_tuser = {fresh_frame, status};

endmodule

/* hdl/tiq_checker.sv */
// port-level checks for the timestamped input queue, bound to the top level
module tiq_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic [1:0]   s_tuser,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [95:0]  m_tdata,
	input logic [2:0]   m_tuser
);
	import tiq_pkg::*;

	// a waiting result holds steady
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// no request is taken while a result is stuck
	a_no_accept_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("request taken while result waits");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser[1:0] == STATUS_OK || m_tuser[1:0] == STATUS_OLD
			|| m_tuser[1:0] == STATUS_FULL)
		else $error("bad status code");

	// fresh flag only comes with a clean status
	a_fresh_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[2] |-> m_tuser[1:0] == STATUS_OK)
		else $error("fresh flag with fault status");

	// a clear request answers next cycle with zeroed channels and step count
	a_clear_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == CMD_CLEAR |=> m_tvalid && m_tdata == '0)
		else $error("clear result not zero");

endmodule

bind timestamped_input_queue_top tiq_checker u_tiq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

/* verif/tb_timestamped_input_queue_top.sv */
// testbench for the timestamped input queue: directed and random requests checked against a predictor
module tb_timestamped_input_queue_top;
	import tiq_pkg::*;

	localparam int RING        = 256;
	localparam int IDLE_LIMIT  = 5000;
	localparam int SETTLE      = 8;

	typedef struct {
		status_t           status;
		logic [CHANS_W-1:0] chans;
		logic              fresh;
		logic [STEP_W-1:0] step;
	} frame_t;

	class queue_scoreboard;
		logic [TIME_W-1:0]  slot_time [RING];
		logic [CHANS_W-1:0] slot_chans [RING];
		int unsigned        rd;
		int unsigned        wr;
		logic [TIME_W-1:0]  last_time;
		bit                 any_pushed;
		logic [CHANS_W-1:0] cur_chans;
		logic [STEP_W-1:0]  step_count;
		logic [PER_W-1:0]   period;
		frame_t             expected_frames [$];
		string              chan_name [4] = '{"roll", "pitch", "yaw", "throttle"};
		int                 errors;
		int                 results;
		int                 n_requests;
		int                 n_stored;
		int                 n_old;
		int                 n_full;
		int                 n_fresh;

		function new();
			period = PERIOD_RESET;
			clear_queue();
		endfunction

		function void clear_queue();
			rd         = 0;
			wr         = 0;
			last_time  = '0;
			any_pushed = 0;
			cur_chans  = '0;
			step_count = '0;
		endfunction

		function int unsigned held();
			return (wr + RING - rd) % RING;
		endfunction

		// works out the result frame that one accepted request produces
		function void predict_frame(cmd_t cmd, logic [TIME_W-1:0] t, logic [CHANS_W-1:0] ch);
			frame_t      f;
			int unsigned nxt;
			bit [63:0]   step_end;
			f.status = STATUS_OK;
			f.fresh  = 0;
			n_requests++;
			case (cmd)
				CMD_PUSH: begin
					nxt = (wr + 1) % RING;
					if (any_pushed && t < last_time) begin
						f.status = STATUS_OLD;
						n_old++;
					end else if (nxt == rd) begin
						f.status = STATUS_FULL;
						n_full++;
					end else begin
						slot_time[wr]  = t;
						slot_chans[wr] = ch;
						wr             = nxt;
						last_time      = t;
						any_pushed     = 1;
						n_stored++;
					end
				end
				CMD_TICK: begin
					// step end is taken before the count advances
					step_end = (64'(step_count) + 64'd1) * 64'(period);
					while (rd != wr && 64'(slot_time[rd]) < step_end) begin
						cur_chans = slot_chans[rd];
						rd        = (rd + 1) % RING;
						f.fresh   = 1;
					end
					if (f.fresh)
						n_fresh++;
					step_count = step_count + 1;
				end
				CMD_CLEAR: begin
					clear_queue();
				end
				default: begin
				end
			endcase
			f.chans = cur_chans;
			f.step  = step_count;
			expected_frames.push_back(f);
		endfunction

		task report(string msg);
			errors++;
			$display("mismatch at %0t: %s", $realtime, msg);
		endtask

		task check_result(logic [95:0] data, logic [2:0] user);
			frame_t f;
			results++;
			if (expected_frames.size() == 0) begin
				report($sformatf("result %0d arrived with no request outstanding", results));
				return;
			end
			f = expected_frames.pop_front();
			if (user[1:0] !== f.status)
				report($sformatf("result %0d status expected %0d got %0d",
					results, f.status, user[1:0]));
			for (int c = 0; c < 4; c++) begin
				if (data[16*c +: 16] !== f.chans[16*c +: 16])
					report($sformatf("result %0d %s expected %04h got %04h", results,
						chan_name[c], f.chans[16*c +: 16], data[16*c +: 16]));
			end
			if (user[2] !== f.fresh)
				report($sformatf("result %0d fresh_frame expected %0d got %0d",
					results, f.fresh, user[2]));
			if (data[95:64] !== f.step)
				report($sformatf("result %0d step_number expected %0d got %0d",
					results, f.step, data[95:64]));
		endtask
	endclass

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [111:0] s_tdata;
	logic [1:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [95:0]  m_tdata;
	logic [2:0]   m_tuser;
	logic         cfg_we;
	logic [15:0]  cfg_wdata;

	queue_scoreboard sb = new();
	bit              quiet;
	int              idle_cycles;
	logic [15:0]     odd_period;

	timestamped_input_queue_top #(
		.QUEUE_DEPTH(RING)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// mostly short gaps, a few long ones, none at all in quiet phases
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 65)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [CHANS_W-1:0] rand_chans();
		return {$urandom, $urandom};
	endfunction

	task automatic send(cmd_t cmd, logic [TIME_W-1:0] t, logic [CHANS_W-1:0] ch);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tuser  <= cmd;
		s_tdata  <= {ch, t};
		do
			@(posedge clk);
		while (!s_tready);
		sb.predict_frame(cmd, t, ch);
	endtask

	task automatic write_period(logic [PER_W-1:0] value);
		s_tvalid <= 0;
		while (sb.expected_frames.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we    <= 1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 0;
		cfg_wdata <= 16'($urandom);
		sb.period = value;
	endtask

	// well-formed timestamp flow with step ticks, some stale pushes, noise, clears and unused commands
	task automatic run_mixed(int count);
		int                r;
		logic [TIME_W-1:0] t;
		bit [63:0]         base;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (r < 55) begin
				if (!sb.any_pushed) begin
					base = 64'(sb.step_count) * 64'(sb.period);
					t = base[TIME_W-1:0] + TIME_W'($urandom_range(0, sb.period));
				end else if ($urandom_range(0, 11) == 0 && sb.last_time != 0) begin
					t = sb.last_time - TIME_W'($urandom_range(1, 1000));
					if (t > sb.last_time)
						t = '0;
				end else begin
					t = sb.last_time + TIME_W'($urandom_range(0, sb.period));
				end
				send(CMD_PUSH, t, rand_chans());
			end else if (r < 85) begin
				send(CMD_TICK, TIME_W'({$urandom, $urandom}), rand_chans());
			end else if (r < 91) begin
				send(CMD_PUSH, TIME_W'({$urandom, $urandom}), rand_chans());
			end else if (r < 96) begin
				send(CMD_CLEAR, TIME_W'({$urandom, $urandom}), rand_chans());
			end else begin
				send(CMD_NOP, TIME_W'({$urandom, $urandom}), rand_chans());
			end
		end
	endtask

	// fills the ring to its limit, then hits it with full and stale pushes and drains it
	task automatic fill_ring();
		send(CMD_CLEAR, '0, '0);
		for (int i = 0; i < RING - 1; i++)
			send(CMD_PUSH, TIME_W'(i * 7), rand_chans());
		send(CMD_PUSH, sb.last_time, rand_chans());
		send(CMD_PUSH, '0, rand_chans());
		send(CMD_TICK, '0, '0);
		send(CMD_TICK, '0, '0);
	endtask

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	initial begin
		int stall;
		stall = 0;
		m_tready <= 0;
		@(posedge clk);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				sb.check_result(m_tdata, m_tuser);
			if (stall > 0) begin
				m_tready <= 0;
				stall--;
			end else begin
				m_tready <= 1;
				stall = pick_gap();
			end
		end
	end

	initial begin
		arst_n    <= 0;
		s_tvalid  <= 0;
		s_tdata   <= '0;
		s_tuser   <= CMD_NOP;
		cfg_we    <= 0;
		cfg_wdata <= '0;
		quiet     = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: empty tick, first and equal pushes, stale pushes, step boundaries
		send(CMD_TICK, '0, '0);
		send(CMD_PUSH, 48'd5000, {16'hFFFF, 16'h0000, 16'h7FFF, 16'h8000});
		send(CMD_PUSH, 48'd5000, {16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000});
		send(CMD_PUSH, 48'd4999, rand_chans());
		send(CMD_PUSH, 48'd0, rand_chans());
		send(CMD_NOP, 48'hFFFF_FFFF_FFFF, {64{1'b1}});
		repeat (4) send(CMD_TICK, '0, '0);
		send(CMD_TICK, '0, '0);
		send(CMD_PUSH, 48'hFFFF_FFFF_FFFF, {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF});
		send(CMD_PUSH, 48'h7FFF_FFFF_FFFF, rand_chans());
		send(CMD_TICK, '0, '0);
		send(CMD_CLEAR, '0, '0);
		send(CMD_PUSH, 48'd0, rand_chans());
		send(CMD_PUSH, 48'd999, rand_chans());
		send(CMD_PUSH, 48'd1000, rand_chans());
		send(CMD_TICK, '0, '0);
		send(CMD_TICK, '0, '0);
		send(CMD_CLEAR, '0, '0);

		write_period(16'd65535);
		quiet = $urandom_range(0, 1);
		fill_ring();
		run_mixed(40);

		write_period(16'd1);
		quiet = ($urandom_range(0, 3) == 0);
		send(CMD_CLEAR, '0, '0);
		run_mixed(60);

		write_period(16'd0);
		quiet = ($urandom_range(0, 3) == 0);
		run_mixed(40);

		odd_period = 16'($urandom_range(2, 65534));
		write_period(odd_period);
		quiet = ($urandom_range(0, 3) == 0);
		send(CMD_CLEAR, '0, '0);
		run_mixed(60);

		write_period(PERIOD_RESET);
		quiet = 0;
		run_mixed(20);

		s_tvalid <= 0;
		while (sb.expected_frames.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);

		$display("%0d requests, %0d results: %0d samples queued, %0d stale, %0d ring full",
			sb.n_requests, sb.results, sb.n_stored, sb.n_old, sb.n_full);
		$display("%0d ticks delivered new samples; periods 1000, 65535, 1, 0 and %0d used",
			sb.n_fresh, odd_period);
		if (sb.errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

/* filelist.f */
hdl/tiq_pkg.sv
hdl/tiq_ctrl.sv
hdl/tiq_datapath.sv
hdl/timestamped_input_queue_top.sv
hdl/tiq_checker.sv
verif/tb_timestamped_input_queue_top.sv
